FILE: hdl/acpt_pkg.sv
package acpt_pkg;

  localparam int VoltW = 17;
  localparam int CurW = 17;
  localparam int PhW = 16;
  localparam int TanW = 16;
  localparam int FrqW = 10;
  localparam int PqW = 28;
  localparam int SW = 27;
  localparam int PfW = 16;
  localparam int CompW = 28;
  localparam int CapW = 27;
  localparam int InW = 56;
  localparam int OutW = 160;

  // CORDIC datapath widths
  localparam int XyW = 34;
  localparam int ZW = 36;
  localparam int AtanEntries = 24;
  localparam int ViW = 34;

  localparam logic [XyW-1:0] CordicGain = XyW'(652032874);
  localparam logic [TanW-1:0] TanReset = 16'd5385;
  localparam logic [FrqW-1:0] FrqReset = 10'd60;

  localparam logic cfg_idx_tan = 1'b0;
  localparam logic cfg_idx_frq = 1'b1;

  typedef logic signed [ZW-1:0] atan_t;
  typedef atan_t atan_tab_t [AtanEntries];

  localparam atan_tab_t AtanTab = '{
    36'sd294912000, 36'sd174096719, 36'sd91987925, 36'sd46694507,
    36'sd23437865, 36'sd11730358, 36'sd5866610, 36'sd2933484,
    36'sd1466764, 36'sd733385, 36'sd366693, 36'sd183346,
    36'sd91673, 36'sd45837, 36'sd22918, 36'sd11459,
    36'sd5730, 36'sd2865, 36'sd1432, 36'sd716,
    36'sd358, 36'sd179, 36'sd90, 36'sd45
  };

  // side data that rides along the cell chain
  typedef struct packed {
    logic [VoltW-1:0] volt;
    logic [CurW-1:0]  cur;
    logic             neg;
    logic             induct;
  } side_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    side_t                 sd;
  } rot_t;

endpackage

FILE: hdl/ac_power_triangle_pf_correction.sv
// Channel | Dir | Beat contents (low bit up)
// in_     | in  | voltage_rms[16:0], current_rms[33:17], phase_angle[49:34]
// out_    | out | active_power, reactive_power, apparent_power, power_factor,
//         |     | inductive_flag, compensation_reactive, capacitance
// cfg_    | in  | index 0 target_tan_ratio, index 1 line_freq_hz
// One beat per cycle unless a stall holds the chain. The path runs through one fold stage,
// the CORDIC cells, eight arithmetic stages and a 63-step divider chain.
// Reset clears the valid bits and loads the config defaults. A stall on out_tready
// freezes the whole chain; in_tready follows out_tready or an empty output slot.
module ac_power_triangle_pf_correction #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [acpt_pkg::InW-1:0] in_tdata,  // voltage_rms, current_rms, phase_angle
  output logic out_tvalid,
  input  logic out_tready,
  output logic [acpt_pkg::OutW-1:0] out_tdata, // active_power .. capacitance
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
  import acpt_pkg::*;

  localparam int Lat = CORDIC_STAGES + 72;

  logic [TanW-1:0] tan_r;
  logic [FrqW-1:0] frq_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_r <= TanReset;
      frq_r <= FrqReset;
    end else if (cfg_valid) begin
      if (cfg_index == cfg_idx_tan) tan_r <= cfg_data;
      else frq_r <= cfg_data[FrqW-1:0];
    end
  end

  logic en;
  logic [Lat-1:0] vld_r;
  assign en = out_tready || !vld_r[Lat-1];
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_tvalid};
  end

  // fold angle into [-90, 90]
  logic signed [PhW+1:0] ph;
  logic neg;
  rot_t f_nxt, f_r;
  always_comb begin
    ph = $signed(in_tdata[49:34]);
    if (ph >= 18000) ph = ph - 36000;
    if (ph < -18000) ph = ph + 36000;
    neg = 1'b0;
    if (ph > 9000) begin ph = ph - 18000; neg = 1'b1; end
    else if (ph < -9000) begin ph = ph + 18000; neg = 1'b1; end
    f_nxt.x = CordicGain;
    f_nxt.y = '0;
    f_nxt.z = ZW'(ph) <<< 16;
    f_nxt.sd.volt = in_tdata[16:0];
    f_nxt.sd.cur = in_tdata[33:17];
    f_nxt.sd.neg = neg;
    f_nxt.sd.induct = !in_tdata[49];
  end

  always_ff @(posedge clk) begin
    if (en) f_r <= f_nxt;
  end

  rot_t ch [CORDIC_STAGES+1];
  assign ch[0] = f_r;
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    acpt_cell #(.Stage(i)) u_cell (.clk(clk), .en(en), .d(ch[i]), .q(ch[i+1]));
  end

  acpt_post u_post (
    .clk(clk), .en(en), .d(ch[CORDIC_STAGES]),
    .tan_ratio(tan_r), .freq(frq_r), .res(out_tdata)
  );
endmodule

FILE: hdl/acpt_cell.sv
module acpt_cell #(
  parameter int Stage = 0
) (
  input  logic          clk,
  input  logic          en,
  input  acpt_pkg::rot_t d,
  output acpt_pkg::rot_t q
);
  import acpt_pkg::*;

  rot_t q_r;
  rot_t q_nxt;
  logic signed [XyW-1:0] dx;
  logic signed [XyW-1:0] dy;

  always_comb begin
    dx = d.y >>> Stage;
    dy = d.x >>> Stage;
    q_nxt = d;
    if (!d.z[ZW-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - AtanTab[Stage];
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + AtanTab[Stage];
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;
endmodule

FILE: hdl/acpt_post.sv
// Power triangle and correction after the rotation. Stall-enabled pipeline.
module acpt_post (
  input  logic                          clk,
  input  logic                          en,
  input  acpt_pkg::rot_t                d,
  input  logic [acpt_pkg::TanW-1:0]     tan_ratio,
  input  logic [acpt_pkg::FrqW-1:0]     freq,
  output logic [acpt_pkg::OutW-1:0]     res
);
  import acpt_pkg::*;

  localparam int CapStg = 63;
  localparam int QcW = 40;

  // stage A: clamp/round/fold, VI and V*V
  logic signed [XyW-1:0] xc, yc;
  logic signed [25:0] c24_a_r, s24_a_r;
  logic signed [PfW:0] pf_a_r;
  logic [ViW-1:0] vi_a_r, vv_a_r;
  logic ind_a_r;

  function automatic logic signed [XyW-1:0] clamp30(input logic signed [XyW-1:0] v);
    if (v > $signed(XyW'(1073741824))) return XyW'(1073741824);
    if (v < -$signed(XyW'(1073741824))) return -$signed(XyW'(1073741824));
    return v;
  endfunction

  logic signed [XyW-1:0] cn, sn_;
  logic signed [XyW-1:0] pfw;
  always_comb begin
    xc = clamp30(d.x);
    yc = clamp30(d.y);
    cn = d.sd.neg ? -xc : xc;
    sn_ = d.sd.neg ? -yc : yc;
    pfw = (cn + XyW'(32768)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c24_a_r <= 26'((cn + XyW'(32)) >>> 6);
      s24_a_r <= 26'((sn_ + XyW'(32)) >>> 6);
      pf_a_r  <= (PfW+1)'(pfw);
      vi_a_r  <= ViW'(d.sd.volt * d.sd.cur);
      vv_a_r  <= ViW'(d.sd.volt * d.sd.volt);
      ind_a_r <= d.sd.induct;
    end
  end

  // stage B: products VI*c24, VI*s24 (split in 17-bit halves), f*V^2
  logic signed [60:0] pc_b_r, ps_b_r;
  logic [ViW-1:0] vi_b_r;
  logic [43:0] den_b_r;
  logic signed [PfW:0] pf_b_r;
  logic ind_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pc_b_r  <= (61'($signed({1'b0, vi_a_r[33:17]}) * c24_a_r) <<< 17)
                 + 61'($signed({1'b0, vi_a_r[16:0]}) * c24_a_r);
      ps_b_r  <= (61'($signed({1'b0, vi_a_r[33:17]}) * s24_a_r) <<< 17)
                 + 61'($signed({1'b0, vi_a_r[16:0]}) * s24_a_r);
      den_b_r <= 44'(vv_a_r * freq);
      vi_b_r  <= vi_a_r;
      pf_b_r  <= pf_a_r;
      ind_b_r <= ind_a_r;
    end
  end

  // stage U: magnitudes plus half the divisor, scaled down by 2^26 (or 4 for S);
  // what is left of the division by 100*2^24 is a quotient by 25
  logic [60:0] pm, qm;
  always_comb begin
    pm = pc_b_r[60] ? 61'(-pc_b_r) : 61'(pc_b_r);
    qm = ps_b_r[60] ? 61'(-ps_b_r) : 61'(ps_b_r);
  end

  logic [32:0] up_u_r, uq_u_r, us_u_r;
  logic np_u_r, nq_u_r;
  logic [43:0] den_u_r;
  logic signed [PfW:0] pf_u_r;
  logic ind_u_r;
  always_ff @(posedge clk) begin
    if (en) begin
      up_u_r <= 33'((pm + 61'd838860800) >> 26);
      uq_u_r <= 33'((qm + 61'd838860800) >> 26);
      us_u_r <= 33'((vi_b_r + ViW'(50)) >> 2);
      np_u_r <= pc_b_r[60];
      nq_u_r <= ps_b_r[60];
      den_u_r <= den_b_r; pf_u_r <= pf_b_r; ind_u_r <= ind_b_r;
    end
  end

  // stage M: reciprocal of 25 (2^38 scale), partial products of a 17-bit high and a 16-bit low part
  localparam logic [33:0] Recip25 = 34'd10995116278;
  logic [50:0] ph_m_r, qh_m_r, sh_m_r;
  logic [49:0] pl_m_r, ql_m_r, sl_m_r;
  logic np_m_r, nq_m_r;
  logic [43:0] den_m_r;
  logic signed [PfW:0] pf_m_r;
  logic ind_m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ph_m_r <= 51'(up_u_r[32:16] * Recip25);
      pl_m_r <= 50'(up_u_r[15:0] * Recip25);
      qh_m_r <= 51'(uq_u_r[32:16] * Recip25);
      ql_m_r <= 50'(uq_u_r[15:0] * Recip25);
      sh_m_r <= 51'(us_u_r[32:16] * Recip25);
      sl_m_r <= 50'(us_u_r[15:0] * Recip25);
      np_m_r <= np_u_r; nq_m_r <= nq_u_r;
      den_m_r <= den_u_r; pf_m_r <= pf_u_r; ind_m_r <= ind_u_r;
    end
  end

  // stage C: finish the quotients, restore the signs of P and Q
  function automatic logic [28:0] quo25(input logic [50:0] hi, input logic [49:0] lo);
    logic [66:0] sum;
    sum = {hi, 16'd0} + 67'(lo);
    return 29'(sum >> 38);
  endfunction

  logic [28:0] pq, qq;
  always_comb begin
    pq = quo25(ph_m_r, pl_m_r);
    qq = quo25(qh_m_r, ql_m_r);
  end

  logic signed [QcW-1:0] p_c_r, q_c_r;
  logic [ViW-1:0] s_c_r;
  logic [43:0] den_c_r;
  logic signed [PfW:0] pf_c_r;
  logic ind_c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_c_r <= np_m_r ? -$signed(QcW'(pq)) : $signed(QcW'(pq));
      q_c_r <= nq_m_r ? -$signed(QcW'(qq)) : $signed(QcW'(qq));
      s_c_r <= ViW'(quo25(sh_m_r, sl_m_r));
      den_c_r <= den_m_r;
      pf_c_r <= pf_m_r;
      ind_c_r <= ind_m_r;
    end
  end

  // stage D: P*tan
  logic signed [QcW+17:0] pt_d_r;
  logic signed [QcW-1:0] p_d_r, q_d_r;
  logic [ViW-1:0] s_d_r;
  logic [43:0] den_d_r;
  logic signed [PfW:0] pf_d_r;
  logic ind_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pt_d_r <= (QcW+18)'(p_c_r * $signed({1'b0, tan_ratio}));
      p_d_r <= p_c_r; q_d_r <= q_c_r; s_d_r <= s_c_r;
      den_d_r <= den_c_r; pf_d_r <= pf_c_r; ind_d_r <= ind_c_r;
    end
  end

  // stage E: Qc = Q - P*tan, clamped at zero, and the need flag
  logic [QcW+17:0] ptm;
  logic signed [QcW-1:0] ptr, qc;
  always_comb begin
    ptm = pt_d_r[QcW+17] ? (QcW+18)'(-pt_d_r) : pt_d_r;
    ptm = (ptm + (QcW+18)'(8192)) >> 14;
    ptr = pt_d_r[QcW+17] ? -$signed(QcW'(ptm)) : $signed(QcW'(ptm));
    qc = q_d_r - ptr;
  end

  logic [QcW-1:0] qc_e_r;
  logic need_e_r;
  logic signed [QcW-1:0] p_e_r, q_e_r;
  logic [ViW-1:0] s_e_r;
  logic [43:0] den_e_r;
  logic signed [PfW:0] pf_e_r;
  logic ind_e_r;
  always_ff @(posedge clk) begin
    if (en) begin
      need_e_r <= qc > 0;
      qc_e_r <= (qc > 0) ? qc : '0;
      p_e_r <= p_d_r; q_e_r <= q_d_r; s_e_r <= s_d_r;
      den_e_r <= den_d_r; pf_e_r <= pf_d_r; ind_e_r <= ind_d_r;
    end
  end

  // stage F: numerator = Qc*K + den/2, restoring divider over CapStg cells
  logic [CapStg+QcW-1:0] num_f;
  assign num_f = (CapStg+QcW)'(qc_e_r) * (CapStg+QcW)'(1591549431)
                 + (CapStg+QcW)'(den_e_r >> 1);

  typedef struct packed {
    logic [CapStg-1:0] quo;
    logic [44:0]       rem;
    logic [CapStg-1:0] num;
  } dv_t;

  dv_t dv_r [CapStg+1];
  logic [CapStg-1:0] nm0;
  assign nm0 = CapStg'(num_f);

  typedef struct packed {
    logic signed [PqW-1:0] p, q;
    logic [SW-1:0] s;
    logic signed [PfW-1:0] pf;
    logic ind, need, dz;
    logic [CompW-1:0] comp;
    logic [43:0] den;
  } tag_t;
  tag_t tg_r [CapStg+1];
  tag_t tg0;

  function automatic logic signed [PqW-1:0] sat_pq(input logic signed [QcW-1:0] v);
    if (v > 134217727) return PqW'(134217727);
    if (v < -134217727) return -$signed(PqW'(134217727));
    return PqW'(v);
  endfunction

  always_comb begin
    tg0.p = sat_pq(p_e_r);
    tg0.q = sat_pq(q_e_r);
    tg0.s = (s_e_r > ViW'(134217727)) ? SW'(134217727) : SW'(s_e_r);
    tg0.pf = (pf_e_r > 16384) ? PfW'(16384) :
             (pf_e_r < -16384) ? -$signed(PfW'(16384)) : PfW'(pf_e_r);
    tg0.ind = ind_e_r;
    tg0.need = need_e_r;
    tg0.dz = den_e_r == '0;
    tg0.comp = (qc_e_r > QcW'(268435455)) ? CompW'(268435455) : CompW'(qc_e_r);
    tg0.den = den_e_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= '{quo: '0, rem: '0, num: nm0};
      tg_r[0] <= tg0;
    end
  end

  for (genvar k = 0; k < CapStg; k++) begin : g_div
    logic [44:0] sh;
    logic ge;
    always_comb begin
      sh = {dv_r[k].rem[43:0], dv_r[k].num[CapStg-1]};
      ge = !tg_r[k].dz && sh >= {1'b0, tg_r[k].den};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1].rem <= ge ? sh - {1'b0, tg_r[k].den} : sh;
        dv_r[k+1].quo <= {dv_r[k].quo[CapStg-2:0], ge};
        dv_r[k+1].num <= {dv_r[k].num[CapStg-2:0], 1'b0};
        tg_r[k+1] <= tg_r[k];
      end
    end
  end

  tag_t tl;
  logic [CapW-1:0] cap;
  always_comb begin
    tl = tg_r[CapStg];
    if (!tl.need) cap = '0;
    else if (tl.dz || dv_r[CapStg].quo > CapStg'(100000000)) cap = CapW'(100000000);
    else cap = CapW'(dv_r[CapStg].quo);
  end

  assign res = {5'b0, cap, tl.need ? tl.comp : CompW'(0), tl.ind, tl.pf, tl.s, tl.q, tl.p};
endmodule

FILE: hdl/acpt_chk.sv
module acpt_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [159:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_pf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[98:83]) <= 16384 && $signed(out_tdata[98:83]) >= -16384)
    else $error("pf");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[127:100] == 0 |-> out_tdata[154:128] == 0) else $error("cap");
endmodule

bind ac_power_triangle_pf_correction acpt_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

FILE: sim/ac_power_triangle_pf_correction_tb.sv
`timescale 1ns / 1ps

module ac_power_triangle_pf_correction_tb;
  import acpt_pkg::*;

  localparam int Stages = 16;
  localparam int DrainCycles = Stages + 72 + 20;

  typedef struct {
    logic signed [PqW-1:0] p;
    logic signed [PqW-1:0] q;
    logic [SW-1:0]         s;
    logic signed [PfW-1:0] pf;
    logic                  induct;
    logic [CompW-1:0]      comp;
    logic [CapW-1:0]       cap;
  } triangle_t;

  class power_triangle_board;
    triangle_t pending[$];
    logic [TanW-1:0] tan_ratio;
    logic [FrqW-1:0] freq_hz;
    int errors;

    function new();
      tan_ratio = TanReset;
      freq_hz = FrqReset;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == cfg_idx_tan) tan_ratio = data;
      else freq_hz = data[FrqW-1:0];
    endfunction

    function longint div_near(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // note an accepted input beat and queue its power triangle
    function void note_input(logic [VoltW-1:0] v, logic [CurW-1:0] c,
                             logic signed [PhW-1:0] ph);
      longint a, x, y, z, dx, dy, c30, s30, c24, s24, vi, pn, qn, sn, qc;
      longint unsigned den, capu;
      bit flip;
      triangle_t e;
      a = ph;
      flip = 0;
      if (a >= 18000) a -= 36000;
      if (a < -18000) a += 36000;
      if (a > 9000) begin
        a -= 18000; flip = 1;
      end else if (a < -9000) begin
        a += 18000; flip = 1;
      end
      x = 652032874; y = 0; z = a * 65536;
      for (int i = 0; i < Stages; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= AtanTab[i];
        end else begin
          x += dx; y -= dy; z += AtanTab[i];
        end
      end
      x = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
      y = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
      c30 = flip ? -x : x;
      s30 = flip ? -y : y;
      c24 = (c30 + 32) >>> 6;
      s24 = (s30 + 32) >>> 6;
      e.pf = PfW'(clip((c30 + 32768) >>> 16, -16384, 16384));
      vi = longint'(v) * longint'(c);
      pn = div_near(vi * c24, 64'sd100 * 64'sd16777216);
      qn = div_near(vi * s24, 64'sd100 * 64'sd16777216);
      sn = (vi + 50) / 100;
      qc = qn - div_near(pn * longint'(tan_ratio), 16384);
      e.comp = 0;
      e.cap = 0;
      if (qc > 0) begin
        e.comp = CompW'(qc > 268435455 ? 268435455 : qc);
        den = longint'(freq_hz) * longint'(v) * longint'(v);
        if (den == 0) capu = 100000000;
        else capu = (longint'(qc) * 64'd1591549431 + den / 2) / den;
        e.cap = CapW'(capu > 100000000 ? 100000000 : capu);
      end
      e.p = PqW'(clip(pn, -134217727, 134217727));
      e.q = PqW'(clip(qn, -134217727, 134217727));
      e.s = SW'(sn > 134217727 ? 134217727 : sn);
      e.induct = ph >= 0;
      pending.push_back(e);
    endfunction

    function void check_result(logic [OutW-1:0] d);
      triangle_t g, e;
      g.p = d[27:0];
      g.q = d[55:28];
      g.s = d[82:56];
      g.pf = d[98:83];
      g.induct = d[99];
      g.comp = d[127:100];
      g.cap = d[154:128];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (g.p !== e.p || g.q !== e.q || g.s !== e.s || g.pf !== e.pf ||
          g.induct !== e.induct || g.comp !== e.comp || g.cap !== e.cap ||
          d[159:155] !== 5'd0) begin
        errors++;
        if (errors <= 10)
          $display({"exp P=%0d Q=%0d S=%0d pf=%0d ind=%0b Qc=%0d C=%0d / ",
                    "got P=%0d Q=%0d S=%0d pf=%0d ind=%0b Qc=%0d C=%0d"},
                   e.p, e.q, e.s, e.pf, e.induct, e.comp, e.cap,
                   g.p, g.q, g.s, g.pf, g.induct, g.comp, g.cap);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [InW-1:0] in_tdata;
  logic [OutW-1:0] out_tdata;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;
  bit steady_in, steady_out;

  power_triangle_board board;

  ac_power_triangle_pf_correction #(.CORDIC_STAGES(Stages)) dut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(negedge clk)
    out_tready <= steady_out || $urandom_range(99) >= 32;

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);

  task automatic send_beat(logic [VoltW-1:0] v, logic [CurW-1:0] c,
                           logic signed [PhW-1:0] ph);
    // idle at random before the beat unless input is steady
    while (!steady_in && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, ph, c, v};
    do @(posedge clk); while (!in_tready);
    board.note_input(v, c, ph);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beats(int n);
    logic [VoltW-1:0] v;
    logic [CurW-1:0] c;
    logic signed [PhW-1:0] ph;
    for (int i = 0; i < n; i++) begin
      steady_in = (i >= n / 3) && (i < n / 3 + 40);
      steady_out = steady_in;
      case ($urandom_range(9))
        0: v = VoltW'($urandom_range(20, 0));
        1, 2: v = VoltW'($urandom_range(100000, 0));
        default: v = VoltW'($urandom);
      endcase
      c = ($urandom_range(9) == 0) ? CurW'($urandom_range(50, 0)) : CurW'($urandom);
      ph = ($urandom_range(7) == 0) ? PhW'($urandom)
                                    : PhW'($urandom_range(36000, 0) - 18000);
      send_beat(v, c, ph);
    end
    steady_in = 0;
    steady_out = 0;
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = cfg_idx_tan;
    cfg_data = '0;
    out_tready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, folds, wraps, no correction, saturations
    send_beat(0, 0, 0);
    send_beat(17'h1FFFF, 17'h1FFFF, 0);
    send_beat(17'h1FFFF, 17'h1FFFF, 9000);
    send_beat(17'h1FFFF, 17'h1FFFF, -9000);
    send_beat(17'h1FFFF, 17'h1FFFF, 18000);
    send_beat(17'h1FFFF, 17'h1FFFF, -18000);
    send_beat(100000, 100000, 17000);
    send_beat(22000, 1500, 3600);
    send_beat(22000, 1500, -3600);
    send_beat(1, 100000, 8000);
    send_beat(0, 100000, 4500);
    send_beat(23000, 2000, 16'sh7FFF);
    send_beat(23000, 2000, 16'sh8000);
    send_beat(23000, 2000, 17999);
    send_beat(23000, 2000, -17999);
    send_beat(23000, 2000, 9001);
    send_beat(23000, 2000, -1);
    send_beat(17'h0AAAA, 17'h15555, 16'sh5555);
    drain();

    write_reg(cfg_idx_tan, 16'hFFFF);
    write_reg(cfg_idx_frq, 16'hFC00);  // frequency field of zero
    send_beat(17'h1FFFF, 17'h1FFFF, 17000);
    send_beat(23000, 2000, 5000);
    random_beats(250);
    drain();

    write_reg(cfg_idx_tan, 16'd0);
    write_reg(cfg_idx_frq, 16'h03E8);
    send_beat(17'h1FFFF, 17'h1FFFF, 9000);
    random_beats(250);
    drain();

    write_reg(cfg_idx_tan, 16'd16384);
    write_reg(cfg_idx_frq, 16'd1);
    random_beats(250);
    drain();

    write_reg(cfg_idx_tan, 16'($urandom));
    write_reg(cfg_idx_frq, 16'h03FF);
    random_beats(150);
    drain();

    write_reg(cfg_idx_tan, 16'd5385);
    write_reg(cfg_idx_frq, 16'd50);
    random_beats(130);
    drain();

    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
